[rtl/wcs_pkg.sv]
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared codes, types and helpers for the wire conductivity scanner.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int PIN_LIMIT      = 8;
  localparam int MIN_TEST_WIRES = 2;

  localparam logic [15:0] DELAY_RESET = 16'd10;
  localparam logic [3:0]  COUNT_RESET = 4'd2;

  // operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_MEASURE = 2'd1;
  localparam logic [1:0] OP_TEST    = 2'd2;
  localparam logic [1:0] OP_TAKE    = 2'd3;

  // sequencer states
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_MEASURE  = 2'd1;
  localparam logic [1:0] MODE_TEST_ON  = 2'd2;
  localparam logic [1:0] MODE_TEST_OFF = 2'd3;

  // register indexes
  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic [7:0] pullup_mask;
    logic       result_ready;
    logic       conductive;
    logic       taken_value;
    logic       calibrated;
    logic       busy_res;
    logic       test_failed;
  } wcs_result_t;

  // one-hot pull-up pattern for a wire, none when the wire has no pin
  function automatic logic [7:0] wire_bit(input logic [3:0] idx);
    logic [7:0] m;
    m = '0;
    if (idx < 4'(PIN_LIMIT)) begin
      m[idx[2:0]] = 1'b1;
    end
    return m;
  endfunction

endpackage

[rtl/wire_conductivity_scanner_top.sv]
// ----------------------------------------------------------------------------
// wire_conductivity_scanner_top
// Tick-driven sequencer for a multi-wire conductivity probe: measurement
// and self-test with settle waits, APB register port.
// ----------------------------------------------------------------------------
// An accepted beat's result is registered in the output register, or in the skid
// entry while the output is stalled. Throughput: one beat per cycle while the skid
// is empty; each beat is a single compare-and-update step on the sequencer
// registers. The two-entry buffer keeps input acceptance going while one result waits.
// Reset (rst_n low, synchronous): sequencer idle, flags clear, buffers empty,
// settle delay = 10 ticks, wires in use = 2.
module wire_conductivity_scanner_top
  import wcs_pkg::*;
#(
  parameter int MAX_WIRES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_pin_levels,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pullup_mask,
  output logic        out_result_ready,
  output logic        out_conductive,
  output logic        out_taken_value,
  output logic        out_calibrated,
  output logic        out_busy_res,
  output logic        out_test_failed
);

  localparam int          EFF_MAX   = (MAX_WIRES < PIN_LIMIT) ? MAX_WIRES : PIN_LIMIT;
  localparam logic [3:0]  EFF_MAX_W = 4'(EFF_MAX);

  logic [15:0] delay_r;
  logic [3:0]  count_r;

  logic [1:0]  mode_r, mode_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        ready_r, ready_nxt;
  logic        outcome_r, outcome_nxt;
  logic        calib_r, calib_nxt;
  logic        fault_r, fault_nxt;
  logic [7:0]  drive_r, drive_nxt;
  logic        taken;

  logic        busy_cur, busy_new;
  logic [3:0]  n_use;
  logic [8:0]  mask_wide;
  logic [7:0]  use_mask;
  logic [7:0]  cur_bit;
  logic [4:0]  idx_inc;
  logic        last_wire;
  logic        settle_hit;
  logic [15:0] timer_dec;

  logic        in_accept, out_take, cfg_write;
  wcs_result_t res;
  wcs_result_t out_r, skid_r;
  logic        out_v_r, skid_v_r;

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_COUNT) ? {28'd0, count_r} : {16'd0, delay_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
      count_r <= COUNT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_DELAY) begin
        delay_r <= pwdata[15:0];
      end else begin
        count_r <= pwdata[3:0];
      end
    end
  end

  assign n_use      = (count_r > EFF_MAX_W) ? EFF_MAX_W : count_r;
  assign mask_wide  = (9'd1 << n_use) - 9'd1;
  assign use_mask   = mask_wide[7:0];
  assign cur_bit    = wire_bit(idx_r);
  assign idx_inc    = {1'b0, idx_r} + 5'd1;
  assign last_wire  = idx_inc >= {1'b0, n_use};
  assign settle_hit = timer_r <= 16'd1;
  assign timer_dec  = settle_hit ? 16'd0 : timer_r - 16'd1;
  assign busy_cur   = mode_r inside {MODE_MEASURE, MODE_TEST_ON, MODE_TEST_OFF};

  always_comb begin
    mode_nxt    = mode_r;
    idx_nxt     = idx_r;
    timer_nxt   = timer_r;
    ready_nxt   = ready_r;
    outcome_nxt = outcome_r;
    calib_nxt   = calib_r;
    fault_nxt   = fault_r;
    drive_nxt   = drive_r;
    taken       = 1'b0;
    case (in_op)
      OP_TICK: begin
        case (mode_r)
          MODE_MEASURE: begin
            timer_nxt = timer_dec;
            if (settle_hit) begin
              if ((in_pin_levels & cur_bit) == 8'd0 || last_wire) begin
                ready_nxt   = 1'b1;
                outcome_nxt = ((in_pin_levels & cur_bit) == 8'd0);
                mode_nxt    = MODE_IDLE;
                drive_nxt   = 8'd0;
                timer_nxt   = 16'd0;
              end else begin
                idx_nxt   = idx_inc[3:0];
                drive_nxt = wire_bit(idx_inc[3:0]);
                timer_nxt = delay_r;
              end
            end
          end
          MODE_TEST_ON: begin
            timer_nxt = timer_dec;
            if (settle_hit) begin
              if ((in_pin_levels & cur_bit) == 8'd0 ||
                  (in_pin_levels & use_mask & ~cur_bit) != 8'd0) begin
                fault_nxt = 1'b1;
                mode_nxt  = MODE_IDLE;
                drive_nxt = 8'd0;
                timer_nxt = 16'd0;
              end else begin
                drive_nxt = 8'd0;
                timer_nxt = delay_r;
                mode_nxt  = MODE_TEST_OFF;
              end
            end
          end
          MODE_TEST_OFF: begin
            timer_nxt = timer_dec;
            if (settle_hit) begin
              if (last_wire) begin
                if ((in_pin_levels & use_mask) == 8'd0) begin
                  calib_nxt = 1'b1;
                end else begin
                  fault_nxt = 1'b1;
                end
                mode_nxt  = MODE_IDLE;
                drive_nxt = 8'd0;
                timer_nxt = 16'd0;
              end else begin
                idx_nxt   = idx_inc[3:0];
                drive_nxt = wire_bit(idx_inc[3:0]);
                timer_nxt = delay_r;
                mode_nxt  = MODE_TEST_ON;
              end
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
      OP_MEASURE: begin
        if (!busy_cur && calib_r) begin
          mode_nxt  = MODE_MEASURE;
          idx_nxt   = 4'd0;
          drive_nxt = wire_bit(4'd0);
          timer_nxt = delay_r;
        end
      end
      OP_TEST: begin
        if (!busy_cur) begin
          if (n_use < 4'(MIN_TEST_WIRES)) begin
            fault_nxt = 1'b1;
            mode_nxt  = MODE_IDLE;
            drive_nxt = 8'd0;
            timer_nxt = 16'd0;
          end else begin
            fault_nxt = 1'b0;
            mode_nxt  = MODE_TEST_ON;
            idx_nxt   = 4'd0;
            drive_nxt = wire_bit(4'd0);
            timer_nxt = delay_r;
          end
        end
      end
      OP_TAKE: begin
        if (ready_r) begin
          taken     = outcome_r;
          ready_nxt = 1'b0;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  assign busy_new = mode_nxt inside {MODE_MEASURE, MODE_TEST_ON, MODE_TEST_OFF};

  always_comb begin
    res.pullup_mask  = drive_nxt;
    res.result_ready = ready_nxt;
    res.conductive   = outcome_nxt;
    res.taken_value  = taken;
    res.calibrated   = calib_nxt;
    res.busy_res     = busy_new;
    res.test_failed  = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      idx_r     <= 4'd0;
      timer_r   <= 16'd0;
      ready_r   <= 1'b0;
      outcome_r <= 1'b0;
      calib_r   <= 1'b0;
      fault_r   <= 1'b0;
      drive_r   <= 8'd0;
    end else if (in_accept) begin
      mode_r    <= mode_nxt;
      idx_r     <= idx_nxt;
      timer_r   <= timer_nxt;
      ready_r   <= ready_nxt;
      outcome_r <= outcome_nxt;
      calib_r   <= calib_nxt;
      fault_r   <= fault_nxt;
      drive_r   <= drive_nxt;
    end
  end

  // output register plus skid entry
  assign in_stall  = skid_v_r;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_take || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_v_r) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (in_accept) begin
        out_r <= res;
      end
    end else if (in_accept) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_pullup_mask  = out_r.pullup_mask;
  assign out_result_ready = out_r.result_ready;
  assign out_conductive   = out_r.conductive;
  assign out_taken_value  = out_r.taken_value;
  assign out_calibrated   = out_r.calibrated;
  assign out_busy_res     = out_r.busy_res;
  assign out_test_failed  = out_r.test_failed;

endmodule

[rtl/wcs_checker.sv]
// ----------------------------------------------------------------------------
// wcs_checker
// Port-level checks for the wire conductivity scanner, bound to the top.
// ----------------------------------------------------------------------------
module wcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pullup_mask,
  input logic       out_result_ready,
  input logic       out_taken_value,
  input logic       out_busy_res
);

  // at most one wire is ever released
  a_one_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_pullup_mask))
    else $error("more than one wire released");

  // a released wire means a sequence is running
  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pullup_mask != 8'd0) |-> out_busy_res)
    else $error("wire released while idle");

  // taking a result clears the waiting flag
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_taken_value) |-> !out_result_ready)
    else $error("result still waiting after take");

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pullup_mask) &&
                                  $stable(out_result_ready) && $stable(out_busy_res)))
    else $error("stalled result beat changed");

endmodule

bind wire_conductivity_scanner_top wcs_checker u_wcs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pullup_mask  (out_pullup_mask),
  .out_result_ready (out_result_ready),
  .out_taken_value  (out_taken_value),
  .out_busy_res     (out_busy_res)
);

[sim/wire_conductivity_scanner_top_tb.sv]
// ----------------------------------------------------------------------------
// wire_conductivity_scanner_top_tb
// Drives tick and command beats into the scanner and checks every result
// beat against a cycle-free model of the sequencer. A directed table covers
// reset values, calibration, measurement and the failure cases. A long
// settle-time phase and random self-test and measurement sequences follow.
// Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module wire_conductivity_scanner_top_tb
  import wcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_MAX_WIRES = 8;
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int RANDOM_BEATS = 900;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  op;
    logic [7:0]  pins;
    int          reps;
    bit          typed;
    wcs_result_t res;
    logic        reg_sel;
    logic [15:0] value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [1:0]  in_op;
  logic [7:0]  in_pin_levels;
  logic        out_valid, out_stall;
  logic [7:0]  out_pullup_mask;
  logic        out_result_ready, out_conductive, out_taken_value;
  logic        out_calibrated, out_busy_res, out_test_failed;

  // scanner model state and its copy of the registers
  logic [1:0]  sc_mode;
  logic [3:0]  sc_wire;
  logic [15:0] sc_settle;
  logic        sc_ready, sc_outcome, sc_cal, sc_fault;
  logic [7:0]  sc_drive;
  logic [15:0] cfg_delay;
  logic [3:0]  cfg_count;

  wcs_result_t expected_results[$];
  stim_row_t   stim_table[$];
  int          errors = 0;
  int          cycles = 0;
  int          beats_sent = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  wire_conductivity_scanner_top #(.MAX_WIRES(TB_MAX_WIRES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_pin_levels(in_pin_levels),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pullup_mask(out_pullup_mask), .out_result_ready(out_result_ready),
    .out_conductive(out_conductive), .out_taken_value(out_taken_value),
    .out_calibrated(out_calibrated), .out_busy_res(out_busy_res),
    .out_test_failed(out_test_failed)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL wire_conductivity_scanner_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic logic [3:0] wires_used();
    logic [3:0] n;
    n = cfg_count;
    if (n > 4'(TB_MAX_WIRES)) n = 4'(TB_MAX_WIRES);
    if (n > 4'(PIN_LIMIT)) n = 4'(PIN_LIMIT);
    return n;
  endfunction

  function automatic logic [7:0] used_mask(input logic [3:0] n);
    logic [8:0] t;
    t = (9'd1 << n) - 9'd1;
    return t[7:0];
  endfunction

  function automatic logic [7:0] released_bit(input logic [3:0] idx);
    return (idx < 4'(PIN_LIMIT)) ? (8'd1 << idx[2:0]) : 8'd0;
  endfunction

  // true on the tick that ends the settle wait
  function automatic bit settle_elapsed();
    if (sc_settle <= 16'd1) begin
      sc_settle = '0;
      return 1'b1;
    end
    sc_settle = sc_settle - 16'd1;
    return 1'b0;
  endfunction

  task automatic release_wire(input logic [3:0] idx);
    sc_wire   = idx;
    sc_drive  = released_bit(idx);
    sc_settle = cfg_delay;
  endtask

  task automatic go_idle();
    sc_mode   = MODE_IDLE;
    sc_drive  = '0;
    sc_settle = '0;
  endtask

  task automatic scan_predict(input logic [1:0] op, input logic [7:0] pins,
                              output wcs_result_t r);
    logic [3:0] n;
    logic [7:0] bitm;
    logic       taken;
    logic       last_wire;
    n         = wires_used();
    bitm      = released_bit(sc_wire);
    taken     = 1'b0;
    last_wire = ({1'b0, sc_wire} + 5'd1) >= {1'b0, n};
    case (op)
      OP_TICK: begin
        case (sc_mode)
          MODE_MEASURE: begin
            if (settle_elapsed()) begin
              sc_drive = '0;
              if ((pins & bitm) == 8'd0) begin
                sc_ready = 1'b1; sc_outcome = 1'b1; go_idle();
              end else if (last_wire) begin
                sc_ready = 1'b1; sc_outcome = 1'b0; go_idle();
              end else begin
                release_wire(sc_wire + 4'd1);
              end
            end
          end
          MODE_TEST_ON: begin
            if (settle_elapsed()) begin
              if ((pins & bitm) == 8'd0 || (pins & used_mask(n) & ~bitm) != 8'd0) begin
                sc_fault = 1'b1; go_idle();
              end else begin
                sc_drive  = '0;
                sc_settle = cfg_delay;
                sc_mode   = MODE_TEST_OFF;
              end
            end
          end
          MODE_TEST_OFF: begin
            if (settle_elapsed()) begin
              if (last_wire) begin
                if ((pins & used_mask(n)) == 8'd0) sc_cal = 1'b1;
                else sc_fault = 1'b1;
                go_idle();
              end else begin
                release_wire(sc_wire + 4'd1);
                sc_mode = MODE_TEST_ON;
              end
            end
          end
          default: sc_mode = MODE_IDLE;
        endcase
      end
      OP_MEASURE: begin
        if (sc_mode == MODE_IDLE && sc_cal) begin
          sc_mode = MODE_MEASURE;
          release_wire(4'd0);
        end
      end
      OP_TEST: begin
        if (sc_mode == MODE_IDLE) begin
          sc_fault = 1'b0;
          if (n < 4'(MIN_TEST_WIRES)) begin
            sc_fault = 1'b1;
            go_idle();
          end else begin
            sc_mode = MODE_TEST_ON;
            release_wire(4'd0);
          end
        end
      end
      default: begin
        if (sc_ready) begin
          taken    = sc_outcome;
          sc_ready = 1'b0;
        end
      end
    endcase
    r.pullup_mask  = sc_drive;
    r.result_ready = sc_ready;
    r.conductive   = sc_outcome;
    r.taken_value  = taken;
    r.calibrated   = sc_cal;
    r.busy_res     = (sc_mode != MODE_IDLE);
    r.test_failed  = sc_fault;
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_beat(input logic [1:0] op, input logic [7:0] pins,
                           input bit typed, input wcs_result_t res);
    int          gap;
    wcs_result_t pred;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_pin_levels <= pins;
    do @(posedge clk); while (in_stall);
    scan_predict(op, pins, pred);
    expected_results.push_back(typed ? res : pred);
    beats_sent++;
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] pins);
    send_beat(op, pins, 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // margin after the last result
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [15:0] value);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_DELAY) cfg_delay = value;
    else cfg_count = value[3:0];
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    wcs_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no pending beat", out_pullup_mask, 0);
      end else begin
        want = expected_results.pop_front();
        check_field("pullup_mask", out_pullup_mask, want.pullup_mask);
        check_field("result_ready", out_result_ready, want.result_ready);
        check_field("conductive", out_conductive, want.conductive);
        check_field("taken_value", out_taken_value, want.taken_value);
        check_field("calibrated", out_calibrated, want.calibrated);
        check_field("busy_res", out_busy_res, want.busy_res);
        check_field("test_failed", out_test_failed, want.test_failed);
      end
    end
  end

  // hold stall in random bursts
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic wcs_result_t res_of(input logic [7:0] mask, input logic rdy,
                                         input logic cond, input logic taken,
                                         input logic cal, input logic busy,
                                         input logic fault);
    wcs_result_t r;
    r = '{pullup_mask: mask, result_ready: rdy, conductive: cond, taken_value: taken,
          calibrated: cal, busy_res: busy, test_failed: fault};
    return r;
  endfunction

  task automatic add_beat(input logic [1:0] op, input logic [7:0] pins, input int reps);
    stim_row_t row;
    row = '{kind: ROW_BEAT, op: op, pins: pins, reps: reps, typed: 1'b0, res: '0,
            reg_sel: 1'b0, value: '0};
    stim_table.push_back(row);
  endtask

  task automatic add_checked(input logic [1:0] op, input logic [7:0] pins,
                             input wcs_result_t res);
    stim_row_t row;
    row = '{kind: ROW_BEAT, op: op, pins: pins, reps: 1, typed: 1'b1, res: res,
            reg_sel: 1'b0, value: '0};
    stim_table.push_back(row);
  endtask

  task automatic add_cfg(input logic reg_sel, input logic [15:0] value);
    stim_row_t row;
    row = '{kind: ROW_CFG, op: OP_TICK, pins: '0, reps: 0, typed: 1'b0, res: '0,
            reg_sel: reg_sel, value: value};
    stim_table.push_back(row);
  endtask

  task automatic run_self_test();
    logic [7:0] pins;
    logic [7:0] used;
    int         guard;
    send_op(OP_TEST, 8'($urandom));
    used  = used_mask(wires_used());
    guard = 0;
    while (sc_mode != MODE_IDLE && guard < 2000) begin
      pins = 8'($urandom) & ~used;
      if (sc_mode == MODE_TEST_ON) pins = pins | sc_drive;
      // rare wiring fault
      if ($urandom_range(0, 39) == 0) pins = pins ^ (8'd1 << $urandom_range(0, 7));
      if ($urandom_range(0, 19) == 0) send_op(2'($urandom_range(1, 3)), 8'($urandom));
      else send_op(OP_TICK, pins);
      guard++;
    end
  endtask

  task automatic run_measurement();
    logic [7:0] pins;
    int         guard;
    send_op(OP_MEASURE, 8'($urandom));
    guard = 0;
    while (sc_mode != MODE_IDLE && guard < 2000) begin
      pins = 8'($urandom);
      if ($urandom_range(0, 4) != 0) pins = pins | sc_drive;
      else pins = pins & ~sc_drive;
      if ($urandom_range(0, 19) == 0) send_op(2'($urandom_range(1, 3)), 8'($urandom));
      else send_op(OP_TICK, pins);
      guard++;
    end
    if ($urandom_range(0, 9) < 7) send_op(OP_TAKE, 8'($urandom));
  endtask

  task automatic new_random_setting();
    logic [15:0] d;
    logic [3:0]  n;
    case ($urandom_range(0, 3))
      0: d = 16'd1;
      1: d = 16'($urandom_range(1, 3));
      2: d = 16'($urandom_range(1, 12));
      default: d = 16'($urandom_range(13, 60));
    endcase
    n = ($urandom_range(0, 9) < 2) ? 4'($urandom_range(0, 1)) : 4'($urandom_range(2, 8));
    if ($urandom_range(0, 3) != 0) write_reg(REG_DELAY, d);
    if ($urandom_range(0, 3) != 0) write_reg(REG_COUNT, {12'd0, n});
  endtask

  initial begin
    int start_beats;
    int seqs;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_op         = OP_TICK;
    in_pin_levels = '0;
    out_stall     = 1'b0;
    cfg_delay     = DELAY_RESET;
    cfg_count     = COUNT_RESET;
    sc_mode       = MODE_IDLE;
    sc_wire       = '0;
    sc_settle     = '0;
    sc_ready      = 1'b0;
    sc_outcome    = 1'b0;
    sc_cal        = 1'b0;
    sc_fault      = 1'b0;
    sc_drive      = '0;

    // values after reset, uncalibrated measurement ignored
    add_checked(OP_TAKE, 8'h00,
                res_of(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_checked(OP_MEASURE, 8'hFF,
                res_of(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_checked(OP_TICK, 8'hFF,
                res_of(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // starts while busy are ignored; wire 0 stuck low fails the test
    add_beat(OP_TEST, 8'h00, 1);
    add_beat(OP_TEST, 8'hFF, 1);
    add_beat(OP_MEASURE, 8'h00, 1);
    add_beat(OP_TICK, 8'h00, 10);
    // passing self-test with the shortest settle
    add_cfg(REG_DELAY, 16'd1);
    add_beat(OP_TEST, 8'h00, 1);
    add_beat(OP_TICK, 8'h01, 1);
    add_beat(OP_TICK, 8'h00, 1);
    add_beat(OP_TICK, 8'h02, 1);
    add_beat(OP_TICK, 8'h00, 1);
    // conductive on wire 1, take twice
    add_beat(OP_MEASURE, 8'hFF, 1);
    add_beat(OP_TICK, 8'h01, 1);
    add_beat(OP_TICK, 8'h00, 1);
    add_checked(OP_TAKE, 8'h00,
                res_of(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    add_checked(OP_TAKE, 8'hFF,
                res_of(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    // open on all wires, then overwrite the waiting result
    add_beat(OP_MEASURE, 8'h00, 1);
    add_beat(OP_TICK, 8'hFF, 2);
    add_beat(OP_MEASURE, 8'h5A, 1);
    add_beat(OP_TICK, 8'h00, 1);
    add_beat(OP_TAKE, 8'hA5, 1);
    // no wires: self-test fails at once, measurement probes wire 0 alone
    add_cfg(REG_COUNT, 16'd0);
    add_checked(OP_TEST, 8'h00,
                res_of(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    add_beat(OP_MEASURE, 8'hFF, 1);
    add_beat(OP_TICK, 8'hFF, 1);
    add_cfg(REG_COUNT, 16'd1);
    add_beat(OP_TEST, 8'hAA, 1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        write_reg(stim_table[i].reg_sel, stim_table[i].value);
      end else begin
        repeat (stim_table[i].reps)
          send_beat(stim_table[i].op, stim_table[i].pins, stim_table[i].typed,
                    stim_table[i].res);
      end
    end

    // long settle with all wires: wire 0 reads low, test faults on the last tick
    write_reg(REG_COUNT, 16'd8);
    write_reg(REG_DELAY, 16'd200);
    send_op(OP_TEST, 8'h00);
    while (sc_mode != MODE_IDLE) send_op(OP_TICK, 8'($urandom) & 8'hFE);
    write_reg(REG_DELAY, 16'd2);

    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      new_random_setting();
      seqs = $urandom_range(4, 10);
      repeat (seqs) begin
        if (beats_sent - start_beats >= RANDOM_BEATS) break;
        if (beats_sent - start_beats > RANDOM_BEATS - 180) calm = 1'b1;
        else calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: run_self_test();
          4, 5, 6, 7: begin
            if (!sc_cal) run_self_test();
            run_measurement();
          end
          default: begin
            repeat ($urandom_range(1, 6)) send_op(2'($urandom), 8'($urandom));
          end
        endcase
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS wire_conductivity_scanner_top");
    end else begin
      $display("FAIL wire_conductivity_scanner_top");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wcs_pkg.sv
rtl/wire_conductivity_scanner_top.sv
rtl/wcs_checker.sv
sim/wire_conductivity_scanner_top_tb.sv
